@@ src/fde_pkg.sv @@
package fde_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_DELAY    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEEDBACK = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIX      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLE   = 4'd3;

   localparam int DELAY_W = 17;
   localparam int FB_W    = 15;
   localparam int MIX_W   = 16;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd24000;
   localparam logic [FB_W-1:0]    FB_RESET    = 15'd13107;
   localparam logic [MIX_W-1:0]   MIX_RESET   = 16'd16384;

   localparam logic [FB_W-1:0]  FB_LIMIT  = 15'd31130;
   localparam logic [MIX_W-1:0] UNITY_Q15 = 16'd32768;

   localparam int FRAC_BITS  = 15;
   localparam int ROUND_HALF = 16384;

endpackage

@@ src/fde_ifs.sv @@
interface fde_req_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic                          channel_in;
   logic signed [SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, output channel_in, output sample_in, input ready);
   modport sink (input valid, input channel_in, input sample_in, output ready);
endinterface

interface fde_rsp_if #(parameter int SAMPLE_BITS = 16) ();
   logic                          valid;
   logic                          ready;
   logic                          channel_out;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   modport source (output valid, output channel_out, output sample_out, input ready);
   modport sink (input valid, input channel_out, input sample_out, output ready);
endinterface

interface fde_csr_if
   import fde_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/feedback_delay_echo.sv @@
// channel   dir   handshake      word
// req_ch    in    valid/ready    channel_in, sample_in
// rsp_ch    out   valid/ready    channel_out, sample_out
// csr_ch    in    valid/ready    index, data (always ready)
//
// one word per cycle unless a hazard or back-pressure stalls it; an accepted word passes
// stage one, store read and products, round and mix into the response register
// the store is one single-port-write, registered-read memory; a word stalls
// in stage one while it reads an entry an earlier word has yet to write
// no clearing pass after reset: wrap flag and write position mark unwritten entries as zero
// a full response register holds the last stage; earlier stages keep filling behind it
module feedback_delay_echo
   import fde_pkg::*;
#(
   parameter int MAX_DELAY   = 131072,
   parameter int SAMPLE_BITS = 16,
   parameter int CHANNELS    = 2
) (
   input  logic      clock,
   input  logic      reset,
   fde_req_if.sink   req_ch,
   fde_rsp_if.source rsp_ch,
   fde_csr_if.sink   csr_ch
);

   localparam int SB        = SAMPLE_BITS;
   localparam int POS_W     = $clog2(MAX_DELAY);
   localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int MEM_DEPTH = CHANNELS * MAX_DELAY;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   function automatic logic [SB-1:0] sat_fn(input logic [SB+3:0] v);
      logic [SB-1:0] r;
      if (v[SB+3:SB-1] == '0 || v[SB+3:SB-1] == '1) begin
         r = v[SB-1:0];
      end else if (v[SB+3]) begin
         r = {1'b1, {(SB-1){1'b0}}};
      end else begin
         r = {1'b0, {(SB-1){1'b1}}};
      end
      return r;
   endfunction

   // configuration
   logic [DELAY_W-1:0] delay_ff;
   logic [FB_W-1:0]    fb_ff;
   logic [MIX_W-1:0]   mix_ff;
   logic               enable_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff  <= DELAY_RESET;
         fb_ff     <= FB_RESET;
         mix_ff    <= MIX_RESET;
         enable_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            REG_DELAY:    delay_ff  <= csr_ch.data[DELAY_W-1:0];
            REG_FEEDBACK: fb_ff     <= csr_ch.data[FB_W-1:0];
            REG_MIX:      mix_ff    <= csr_ch.data[MIX_W-1:0];
            REG_ENABLE:   enable_ff <= csr_ch.data[0];
            default: ;
         endcase
      end
   end

   // write positions and fill state
   logic [POS_W-1:0] wp_ff [CHANNELS];
   logic             wrap_ff [CHANNELS];

   // pipeline registers
   logic              s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic              s1_ch_ff, s2_ch_ff, s3_ch_ff, out_ch_ff;
   logic [SB-1:0]     s1_dry_ff, s2_dry_ff, s3_dry_ff, out_sample_ff;
   logic              s1_active_ff, s2_active_ff, s3_active_ff;
   logic              s1_fill_ff, s2_fill_ff;
   logic [ADDR_W-1:0] s1_raddr_ff, s1_waddr_ff, s2_waddr_ff, s3_waddr_ff;
   logic [SB-1:0]     rd_ff;
   logic [SB+15:0]    pfb_ff;
   logic [SB+16:0]    pdry_ff, pwet_ff;

   // stage three sums
   logic [SB+16:0] fb_sum;
   logic [SB+1:0]  fb_q;
   logic [SB+17:0] mix_sum;
   logic [SB+2:0]  mix_q;

   logic [SB-1:0] mem [MEM_DEPTH];

   // request decode
   logic             ch_ok, active_w, fill_w, wrap_in, req_accept;
   logic [CH_W-1:0]  ch_sel;
   logic [POS_W-1:0] cur_wp, rp_w, wp_in;
   logic [31:0]      dly32;
   logic [POS_W:0]   d_eff, wp_ext, rp_ext;
   logic [ADDR_W-1:0] base_w, raddr_w, waddr_w;

   always_comb begin
      ch_ok  = 32'(req_ch.channel_in) < 32'(CHANNELS);
      ch_sel = ch_ok ? CH_W'(req_ch.channel_in) : '0;
      cur_wp = wp_ff[ch_sel];
      active_w = enable_ff && ch_ok;

      dly32 = 32'(delay_ff);
      if (dly32 == 32'd0) begin
         dly32 = 32'd1;
      end
      if (dly32 > 32'(MAX_DELAY)) begin
         dly32 = 32'(MAX_DELAY);
      end
      d_eff  = dly32[POS_W:0];
      wp_ext = {1'b0, cur_wp};
      if (wp_ext >= d_eff) begin
         rp_ext = wp_ext - d_eff;
      end else begin
         rp_ext = wp_ext + (POS_W+1)'(MAX_DELAY) - d_eff;
      end
      rp_w   = rp_ext[POS_W-1:0];
      fill_w = wrap_ff[ch_sel] || (rp_w < cur_wp);

      base_w  = ADDR_W'(32'(ch_sel) * 32'(MAX_DELAY));
      raddr_w = base_w + ADDR_W'(rp_w);
      waddr_w = base_w + ADDR_W'(cur_wp);

      wrap_in = cur_wp == POS_W'(MAX_DELAY - 1);
      wp_in   = wrap_in ? '0 : cur_wp + 1'b1;
   end

   // stage control
   logic adv1, adv2, adv3, haz1, mem_we;

   always_comb begin
      adv3 = s3_v_ff && (!out_v_ff || rsp_ch.ready);
      adv2 = s2_v_ff && (!s3_v_ff || adv3);
      haz1 = s1_active_ff &&
             ((s2_v_ff && s2_active_ff && (s2_waddr_ff == s1_raddr_ff)) ||
              (s3_v_ff && s3_active_ff && (s3_waddr_ff == s1_raddr_ff)));
      adv1 = s1_v_ff && (!s2_v_ff || adv2) && !haz1;
      mem_we = adv3 && s3_active_ff;
   end

   assign req_ch.ready = !s1_v_ff || adv1;
   assign req_accept   = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wp_ff[i]   <= '0;
            wrap_ff[i] <= 1'b0;
         end
      end else if (req_accept && active_w) begin
         wp_ff[ch_sel] <= wp_in;
         if (wrap_in) begin
            wrap_ff[ch_sel] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_v_ff <= 1'b1;
         end else if (adv1) begin
            s1_v_ff <= 1'b0;
         end
         if (adv1) begin
            s2_v_ff <= 1'b1;
         end else if (adv2) begin
            s2_v_ff <= 1'b0;
         end
         if (adv2) begin
            s3_v_ff <= 1'b1;
         end else if (adv3) begin
            s3_v_ff <= 1'b0;
         end
         if (adv3) begin
            out_v_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   // delay store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[s3_waddr_ff] <= sat_fn({{4{s3_dry_ff[SB-1]}}, s3_dry_ff} +
                                    {{2{fb_q[SB+1]}}, fb_q});
      end
      if (adv1) begin
         rd_ff <= mem[s1_raddr_ff];
      end
   end

   // stage one: address and fill state
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ch_ff     <= req_ch.channel_in;
         s1_dry_ff    <= req_ch.sample_in;
         s1_active_ff <= active_w;
         s1_fill_ff   <= fill_w;
         s1_raddr_ff  <= raddr_w;
         s1_waddr_ff  <= waddr_w;
      end
   end

   // stage two: read data arrives, products
   always_ff @(posedge clock) begin
      if (adv1) begin
         s2_ch_ff     <= s1_ch_ff;
         s2_dry_ff    <= s1_dry_ff;
         s2_active_ff <= s1_active_ff;
         s2_fill_ff   <= s1_fill_ff;
         s2_waddr_ff  <= s1_waddr_ff;
      end
   end

   logic [FB_W-1:0]         fb_c;
   logic [MIX_W-1:0]        mix_c, dry_gain;
   logic signed [SB-1:0]    delayed;

   always_comb begin
      fb_c     = (fb_ff > FB_LIMIT) ? FB_LIMIT : fb_ff;
      mix_c    = (mix_ff > UNITY_Q15) ? UNITY_Q15 : mix_ff;
      dry_gain = UNITY_Q15 - mix_c;
      delayed  = s2_fill_ff ? $signed(rd_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s3_ch_ff     <= s2_ch_ff;
         s3_dry_ff    <= s2_dry_ff;
         s3_active_ff <= s2_active_ff;
         s3_waddr_ff  <= s2_waddr_ff;
         pfb_ff  <= delayed * $signed({1'b0, fb_c});
         pdry_ff <= $signed(s2_dry_ff) * $signed({1'b0, dry_gain});
         pwet_ff <= delayed * $signed({1'b0, mix_c});
      end
   end

   // stage three: round, saturate, write back and mix
   always_comb begin
      fb_sum  = {pfb_ff[SB+15], pfb_ff} + (SB+17)'(ROUND_HALF);
      fb_q    = fb_sum[SB+16:FRAC_BITS];
      mix_sum = {pdry_ff[SB+16], pdry_ff} + {pwet_ff[SB+16], pwet_ff} +
                (SB+18)'(ROUND_HALF);
      mix_q   = mix_sum[SB+17:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         out_ch_ff     <= s3_ch_ff;
         out_sample_ff <= s3_active_ff ? sat_fn({mix_q[SB+2], mix_q}) : '0;
      end
   end

   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.channel_out = out_ch_ff;
   assign rsp_ch.sample_out  = out_sample_ff;

   a_no_stale_read: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && adv1 && s1_active_ff && (s1_raddr_ff == s3_waddr_ff)))
      else $error("store read overlaps a pending write");

   a_wp_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && active_w) |=> $stable(wp_ff[0]) && $stable(wrap_ff[0]))
      else $error("write position moved without an active word");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (adv3 && !s3_active_ff) |=> (out_sample_ff == '0))
      else $error("inactive word gave a non-zero sample");

endmodule
